// File: rtl/preamble_correlator_peak_detect_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the preamble correlator
// Shared property wrappers, clocked on clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef PREAMBLE_CORRELATOR_PEAK_DETECT_DEFINES_SVH
`define PREAMBLE_CORRELATOR_PEAK_DETECT_DEFINES_SVH

// same-cycle implication
`define PCPD_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define PCPD_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/pcpd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Preamble correlator package
// Widths, field offsets, register codes, stage controls and tap geometry.
// ----------------------------------------------------------------------------
package pcpd_pkg;

	localparam int SAMPLE_W    = 16;
	localparam int ACC_W       = 22;
	localparam int ABS_W       = 21;
	localparam int SUM_W       = 22;
	localparam int PROD_W      = 26;
	localparam int MAG_W       = 21;
	localparam int THR_W       = 21;
	localparam int PAT_W       = 32;
	localparam int CFG_W       = 32;
	localparam int CFG_IDX_W   = 1;
	localparam int IN_TDATA_W  = 32;
	localparam int OUT_TDATA_W = 56;
	localparam int OUT_I_LSB   = 0;
	localparam int OUT_Q_LSB   = 16;
	localparam int OUT_MAG_LSB = 32;
	localparam int OUT_PEAK    = 53;
	localparam int GROUP       = 4;

	localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_PATTERN   = 1'b1;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] q;
		logic signed [SAMPLE_W-1:0] i;
	} pcpd_iq_t;

	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
		logic s5;
		logic s6;
	} pcpd_ld_t;

	function automatic int num_taps(int n, int s);
		return (s > 1) ? n : n - 1;
	endfunction

	function automatic int num_terms(int n, int s);
		return num_taps(n, s) + 1;
	endfunction

	function automatic int tap_pos(int n, int s, int k);
		return (k < num_taps(n, s)) ? n * s - 1 - k * s : 0;
	endfunction

	function automatic int tap_bit(int n, int s, int k);
		return (k < num_taps(n, s)) ? n - 1 - k : 0;
	endfunction

	function automatic logic signed [ACC_W-1:0] sx(logic [SAMPLE_W-1:0] v);
		return {{(ACC_W - SAMPLE_W){v[SAMPLE_W-1]}}, v};
	endfunction

endpackage

// File: rtl/pcpd_line.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sample delay line
// I/Q shift line; exposes the post-shift tap values and the oldest sample.
// ----------------------------------------------------------------------------
module pcpd_line #(
	parameter int N = 32,
	parameter int S = 4,
	localparam int L = N * S,
	localparam int T = pcpd_pkg::num_terms(N, S)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               shift,
	input  pcpd_pkg::pcpd_iq_t smp,
	output pcpd_pkg::pcpd_iq_t tap [T],
	output pcpd_pkg::pcpd_iq_t oldest
);

	pcpd_pkg::pcpd_iq_t line_q [L];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int p = 0; p < L; p++) line_q[p] <= '0;
		end else if (shift) begin
			line_q[0] <= smp;
			for (int p = 1; p < L; p++) line_q[p] <= line_q[p-1];
		end
	end

	for (genvar k = 0; k < T; k++) begin : g_tap
		localparam int P = pcpd_pkg::tap_pos(N, S, k);
		if (P == 0) begin : g_new
			assign tap[k] = smp;
		end else begin : g_old
			assign tap[k] = line_q[P-1];
		end
	end

	assign oldest = line_q[L-2];

endmodule

// File: rtl/pcpd_corr.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Correlation adder tree
// Signs each tap by its pattern bit and sums in three registered levels.
// ----------------------------------------------------------------------------
module pcpd_corr #(
	parameter int N = 32,
	parameter int S = 4,
	localparam int T = pcpd_pkg::num_terms(N, S)
) (
	input  logic                                clk,
	input  pcpd_pkg::pcpd_ld_t                  ld,
	input  logic [pcpd_pkg::PAT_W-1:0]          pattern,
	input  pcpd_pkg::pcpd_iq_t                  tap [T],
	output logic signed [pcpd_pkg::ACC_W-1:0]   acc_i_s3,
	output logic signed [pcpd_pkg::ACC_W-1:0]   acc_q_s3
);

	localparam int AW = pcpd_pkg::ACC_W;
	localparam int GP = pcpd_pkg::GROUP;
	localparam int G1 = (T + GP - 1) / GP;
	localparam int G2 = (G1 + GP - 1) / GP;

	logic signed [AW-1:0] term_i [T];
	logic signed [AW-1:0] term_q [T];
	logic signed [AW-1:0] n1_i [G1];
	logic signed [AW-1:0] n1_q [G1];
	logic signed [AW-1:0] grp_i_s1 [G1];
	logic signed [AW-1:0] grp_q_s1 [G1];
	logic signed [AW-1:0] n2_i [G2];
	logic signed [AW-1:0] n2_q [G2];
	logic signed [AW-1:0] grp_i_s2 [G2];
	logic signed [AW-1:0] grp_q_s2 [G2];
	logic signed [AW-1:0] n3_i;
	logic signed [AW-1:0] n3_q;

	for (genvar k = 0; k < T; k++) begin : g_term
		localparam int B = pcpd_pkg::tap_bit(N, S, k);
		assign term_i[k] = pattern[B] ? pcpd_pkg::sx(tap[k].i) : -pcpd_pkg::sx(tap[k].i);
		assign term_q[k] = pattern[B] ? pcpd_pkg::sx(tap[k].q) : -pcpd_pkg::sx(tap[k].q);
	end

	always_comb begin
		for (int g = 0; g < G1; g++) begin
			n1_i[g] = '0;
			n1_q[g] = '0;
			for (int j = 0; j < GP; j++) begin
				if (g * GP + j < T) begin
					n1_i[g] = n1_i[g] + term_i[g*GP+j];
					n1_q[g] = n1_q[g] + term_q[g*GP+j];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ld.s1) begin
			grp_i_s1 <= n1_i;
			grp_q_s1 <= n1_q;
		end
	end

	always_comb begin
		for (int g = 0; g < G2; g++) begin
			n2_i[g] = '0;
			n2_q[g] = '0;
			for (int j = 0; j < GP; j++) begin
				if (g * GP + j < G1) begin
					n2_i[g] = n2_i[g] + grp_i_s1[g*GP+j];
					n2_q[g] = n2_q[g] + grp_q_s1[g*GP+j];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ld.s2) begin
			grp_i_s2 <= n2_i;
			grp_q_s2 <= n2_q;
		end
	end

	always_comb begin
		n3_i = '0;
		n3_q = '0;
		for (int g = 0; g < G2; g++) begin
			n3_i = n3_i + grp_i_s2[g];
			n3_q = n3_q + grp_q_s2[g];
		end
	end

	always_ff @(posedge clk) begin
		if (ld.s3) begin
			acc_i_s3 <= n3_i;
			acc_q_s3 <= n3_q;
		end
	end

endmodule

// File: rtl/pcpd_mag.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Magnitude estimator
// Larger plus half the smaller absolute sum, scaled by fifteen sixteenths.
// ----------------------------------------------------------------------------
module pcpd_mag (
	input  logic                                clk,
	input  pcpd_pkg::pcpd_ld_t                  ld,
	input  logic signed [pcpd_pkg::ACC_W-1:0]   acc_i_s3,
	input  logic signed [pcpd_pkg::ACC_W-1:0]   acc_q_s3,
	output logic [pcpd_pkg::MAG_W-1:0]          mag_s5
);

	localparam int AW = pcpd_pkg::ACC_W;
	localparam int BW = pcpd_pkg::ABS_W;
	localparam int SW = pcpd_pkg::SUM_W;
	localparam int PW = pcpd_pkg::PROD_W;
	localparam int MW = pcpd_pkg::MAG_W;

	logic signed [AW-1:0] neg_i;
	logic signed [AW-1:0] neg_q;
	logic [BW-1:0]        abs_i;
	logic [BW-1:0]        abs_q;
	logic [BW-1:0]        big_s4;
	logic [BW-1:0]        small_s4;
	logic [SW-1:0]        sum;
	logic [PW-1:0]        prod;

	assign neg_i = -acc_i_s3;
	assign neg_q = -acc_q_s3;
	assign abs_i = acc_i_s3[AW-1] ? neg_i[BW-1:0] : acc_i_s3[BW-1:0];
	assign abs_q = acc_q_s3[AW-1] ? neg_q[BW-1:0] : acc_q_s3[BW-1:0];

	always_ff @(posedge clk) begin
		if (ld.s4) begin
			big_s4   <= (abs_i >= abs_q) ? abs_i : abs_q;
			small_s4 <= (abs_i >= abs_q) ? abs_q : abs_i;
		end
	end

	assign sum  = SW'(big_s4) + SW'(small_s4 >> 1);
	assign prod = {sum, 4'b0000} - PW'(sum);

	always_ff @(posedge clk) begin
		if (ld.s5) begin
			mag_s5 <= prod[MW+3:4];
		end
	end

endmodule

// File: rtl/preamble_correlator_peak_detect.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Preamble correlator with peak detection
// Matched filter against a binary preamble over an I/Q delay line, with an
// approximate magnitude and a running-peak flag above a threshold.
// ----------------------------------------------------------------------------
// Channel   Dir  Handshake            Payload
// in        in   in_tvalid/in_tready  in_tdata: sample_i, sample_q
// out       out  out_tvalid/out_tready out_tdata: delayed_i, delayed_q, magnitude,
//                                     new_peak
// cfg       in   cfg_wen              cfg_idx, cfg_wdata
//
// One transaction per cycle sustained while out_tready stays high; six register
// stages, set by the adder tree and magnitude stages: each input transaction
// passes through vld_q[1] to vld_q[6] in order before out_tvalid rises.
// Reset clears the delay line, the running peak, the threshold and pattern registers and all valids.
// Each stage holds only while the next one is full and stalled, so a stall on
// out backs up through bubbles before in_tready drops.
// ----------------------------------------------------------------------------
module preamble_correlator_peak_detect #(
	parameter int PREAMBLE_SYMBOLS   = 32,
	parameter int SAMPLES_PER_SYMBOL = 4
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_tvalid,
	output logic                                 in_tready,
	// sample_i[15:0], sample_q[31:16]
	input  logic [pcpd_pkg::IN_TDATA_W-1:0]      in_tdata,
	output logic                                 out_tvalid,
	input  logic                                 out_tready,
	// delayed_i[15:0], delayed_q[31:16], magnitude[52:32], new_peak[53], zero
	output logic [pcpd_pkg::OUT_TDATA_W-1:0]     out_tdata,
	input  logic                                 cfg_wen,
	input  logic [pcpd_pkg::CFG_IDX_W-1:0]       cfg_idx,
	input  logic [pcpd_pkg::CFG_W-1:0]           cfg_wdata
);

	localparam int T = pcpd_pkg::num_terms(PREAMBLE_SYMBOLS, SAMPLES_PER_SYMBOL);

	logic [pcpd_pkg::THR_W-1:0]          thr_q;
	logic [pcpd_pkg::PAT_W-1:0]          pat_q;
	logic [pcpd_pkg::MAG_W-1:0]          peak_q;
	logic [6:1]                          vld_q;
	logic [7:1]                          rdy;
	pcpd_pkg::pcpd_ld_t                  ld;
	pcpd_pkg::pcpd_iq_t                  smp;
	pcpd_pkg::pcpd_iq_t                  tap [T];
	pcpd_pkg::pcpd_iq_t                  oldest;
	pcpd_pkg::pcpd_iq_t                  dly_s1;
	pcpd_pkg::pcpd_iq_t                  dly_s2;
	pcpd_pkg::pcpd_iq_t                  dly_s3;
	pcpd_pkg::pcpd_iq_t                  dly_s4;
	pcpd_pkg::pcpd_iq_t                  dly_s5;
	pcpd_pkg::pcpd_iq_t                  dly_s6;
	logic signed [pcpd_pkg::ACC_W-1:0]   acc_i_s3;
	logic signed [pcpd_pkg::ACC_W-1:0]   acc_q_s3;
	logic [pcpd_pkg::MAG_W-1:0]          mag_s5;
	logic [pcpd_pkg::MAG_W-1:0]          mag_s6;
	logic                                peak_s6;
	logic                                hit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= '0;
			pat_q <= '0;
		end else if (cfg_wen) begin
			unique case (cfg_idx)
				pcpd_pkg::REG_THRESHOLD: thr_q <= cfg_wdata[pcpd_pkg::THR_W-1:0];
				pcpd_pkg::REG_PATTERN:   pat_q <= cfg_wdata[pcpd_pkg::PAT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		rdy[7] = out_tready;
		for (int k = 6; k >= 1; k--) rdy[k] = !vld_q[k] || rdy[k+1];
	end

	assign ld.s1 = in_tvalid && rdy[1];
	assign ld.s2 = vld_q[1] && rdy[2];
	assign ld.s3 = vld_q[2] && rdy[3];
	assign ld.s4 = vld_q[3] && rdy[4];
	assign ld.s5 = vld_q[4] && rdy[5];
	assign ld.s6 = vld_q[5] && rdy[6];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (rdy[1]) vld_q[1] <= in_tvalid;
			for (int k = 2; k <= 6; k++) begin
				if (rdy[k]) vld_q[k] <= vld_q[k-1];
			end
		end
	end

	assign in_tready  = rdy[1];
	assign out_tvalid = vld_q[6];
	assign smp        = in_tdata;

	pcpd_line #(
		.N(PREAMBLE_SYMBOLS),
		.S(SAMPLES_PER_SYMBOL)
	) u_line (
		.clk   (clk),
		.arst_n(arst_n),
		.shift (ld.s1),
		.smp   (smp),
		.tap   (tap),
		.oldest(oldest)
	);

	pcpd_corr #(
		.N(PREAMBLE_SYMBOLS),
		.S(SAMPLES_PER_SYMBOL)
	) u_corr (
		.clk     (clk),
		.ld      (ld),
		.pattern (pat_q),
		.tap     (tap),
		.acc_i_s3(acc_i_s3),
		.acc_q_s3(acc_q_s3)
	);

	pcpd_mag u_mag (
		.clk     (clk),
		.ld      (ld),
		.acc_i_s3(acc_i_s3),
		.acc_q_s3(acc_q_s3),
		.mag_s5  (mag_s5)
	);

	always_ff @(posedge clk) begin
		if (ld.s1) dly_s1 <= oldest;
		if (ld.s2) dly_s2 <= dly_s1;
		if (ld.s3) dly_s3 <= dly_s2;
		if (ld.s4) dly_s4 <= dly_s3;
		if (ld.s5) dly_s5 <= dly_s4;
		if (ld.s6) begin
			dly_s6  <= dly_s5;
			mag_s6  <= mag_s5;
			peak_s6 <= hit;
		end
	end

	assign hit = (mag_s5 > thr_q) && (mag_s5 > peak_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			peak_q <= '0;
		end else if (ld.s6 && hit) begin
			peak_q <= mag_s5;
		end
	end

	assign out_tdata = {2'b00, peak_s6, mag_s6, dly_s6.q, dly_s6.i};

endmodule

// File: rtl/pcpd_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Preamble correlator port checker
// Tracks threshold and running peak from the ports, checks the peak flag and that a stalled output holds.
// ----------------------------------------------------------------------------
`include "preamble_correlator_peak_detect_defines.svh"

module pcpd_chk (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              cfg_wen,
	input logic [pcpd_pkg::CFG_IDX_W-1:0]    cfg_idx,
	input logic [pcpd_pkg::CFG_W-1:0]        cfg_wdata,
	input logic                              out_tvalid,
	input logic                              out_tready,
	input logic [pcpd_pkg::OUT_TDATA_W-1:0]  out_tdata
);

	logic [pcpd_pkg::THR_W-1:0] thr_q;
	logic [pcpd_pkg::MAG_W-1:0] peak_q;
	logic [pcpd_pkg::MAG_W-1:0] mag;
	logic                       flag;
	logic                       xfer;

	assign mag  = out_tdata[pcpd_pkg::OUT_MAG_LSB +: pcpd_pkg::MAG_W];
	assign flag = out_tdata[pcpd_pkg::OUT_PEAK];
	assign xfer = out_tvalid && out_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q  <= '0;
			peak_q <= '0;
		end else begin
			if (cfg_wen && cfg_idx == pcpd_pkg::REG_THRESHOLD) begin
				thr_q <= cfg_wdata[pcpd_pkg::THR_W-1:0];
			end
			if (xfer && flag) peak_q <= mag;
		end
	end

	`PCPD_ASSERT_IMP(a_peak_rises, xfer && flag, mag > peak_q, "flagged magnitude not above peak")
	`PCPD_ASSERT_IMP(a_peak_thr, xfer && flag, mag > thr_q, "flagged magnitude not above threshold")
	`PCPD_ASSERT_IMP(a_peak_missed, xfer && mag > thr_q && mag > peak_q, flag, "peak not flagged")
	`PCPD_ASSERT_NXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "output dropped while stalled")

endmodule

bind preamble_correlator_peak_detect pcpd_chk u_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.cfg_wen   (cfg_wen),
	.cfg_idx   (cfg_idx),
	.cfg_wdata (cfg_wdata),
	.out_tvalid(out_tvalid),
	.out_tready(out_tready),
	.out_tdata (out_tdata)
);

// File: test/tb_preamble_correlator_peak_detect.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the preamble correlator with peak detection
// Streams I/Q samples through the block and predicts each result: the oldest
// delayed sample, the correlation magnitude and the running-peak flag. Bursts
// of the programmed preamble at growing amplitude (some corrupted), mixed with
// noise, run under several threshold and pattern settings. Both stream sides
// idle at random.
// ----------------------------------------------------------------------------
module tb_preamble_correlator_peak_detect;

	localparam int NSYM        = 32;
	localparam int SPS         = 4;
	localparam int LINE_LEN    = NSYM * SPS;
	localparam int STALL_LIMIT = 4000;
	localparam int PHASE_ITEMS = 100;
	localparam int SW          = pcpd_pkg::SAMPLE_W;
	localparam int MW          = pcpd_pkg::MAG_W;

	typedef struct {
		logic signed [SW-1:0] delayed_i;
		logic signed [SW-1:0] delayed_q;
		logic [MW-1:0]        magnitude;
		logic                 new_peak;
	} corr_result_t;

	class corr_scoreboard;
		int                             line_i[LINE_LEN];
		int                             line_q[LINE_LEN];
		logic [pcpd_pkg::THR_W-1:0]     thr;
		logic [pcpd_pkg::PAT_W-1:0]     pat;
		logic [MW-1:0]                  peak;
		corr_result_t                   pending[$];
		int                             errors;

		function void clear();
			foreach (line_i[k]) begin
				line_i[k] = 0;
				line_q[k] = 0;
			end
			thr = '0;
			pat = '0;
			peak = '0;
			errors = 0;
		endfunction

		function void set_reg(logic [pcpd_pkg::CFG_IDX_W-1:0] idx,
			logic [pcpd_pkg::CFG_W-1:0] v);
			case (idx)
				pcpd_pkg::REG_THRESHOLD: thr = v[pcpd_pkg::THR_W-1:0];
				pcpd_pkg::REG_PATTERN:   pat = v[pcpd_pkg::PAT_W-1:0];
				default: ;
			endcase
		endfunction

		function int tap(int v, int b);
			return pat[b] ? v : -v;
		endfunction

		function void note_sample(pcpd_pkg::pcpd_iq_t s);
			int acc_i, acc_q, b, ai, aq, big, sml;
			longint w;
			corr_result_t r;
			for (int k = LINE_LEN - 1; k > 0; k--) begin
				line_i[k] = line_i[k-1];
				line_q[k] = line_q[k-1];
			end
			line_i[0] = int'(s.i);
			line_q[0] = int'(s.q);
			acc_i = 0;
			acc_q = 0;
			b = NSYM - 1;
			for (int p = LINE_LEN - 1; p > 0; p -= SPS) begin
				if (b >= 0) begin
					acc_i += tap(line_i[p], b);
					acc_q += tap(line_q[p], b);
				end
				b--;
			end
			acc_i += tap(line_i[0], 0);
			acc_q += tap(line_q[0], 0);
			ai = acc_i < 0 ? -acc_i : acc_i;
			aq = acc_q < 0 ? -acc_q : acc_q;
			big = ai >= aq ? ai : aq;
			sml = ai >= aq ? aq : ai;
			w = ((longint'(big) + longint'(sml >> 1)) * 15) >>> 4;
			if (w > 2097151)
				w = 2097151;
			r.magnitude = w[MW-1:0];
			r.new_peak = 1'b0;
			if (r.magnitude > thr && r.magnitude > peak) begin
				peak = r.magnitude;
				r.new_peak = 1'b1;
			end
			r.delayed_i = line_i[LINE_LEN-1][SW-1:0];
			r.delayed_q = line_q[LINE_LEN-1][SW-1:0];
			pending.push_back(r);
		endfunction

		function void check_result(logic [pcpd_pkg::OUT_TDATA_W-1:0] td);
			corr_result_t e, a;
			a.delayed_i = td[pcpd_pkg::OUT_I_LSB +: SW];
			a.delayed_q = td[pcpd_pkg::OUT_Q_LSB +: SW];
			a.magnitude = td[pcpd_pkg::OUT_MAG_LSB +: MW];
			a.new_peak  = td[pcpd_pkg::OUT_PEAK];
			if (pending.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual i %0d q %0d mag %0d peak %0b",
					$time, a.delayed_i, a.delayed_q, a.magnitude, a.new_peak);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (a.delayed_i !== e.delayed_i) begin
				$display("%0t: delayed_i expected %0d actual %0d", $time, e.delayed_i, a.delayed_i);
				errors++;
			end
			if (a.delayed_q !== e.delayed_q) begin
				$display("%0t: delayed_q expected %0d actual %0d", $time, e.delayed_q, a.delayed_q);
				errors++;
			end
			if (a.magnitude !== e.magnitude) begin
				$display("%0t: magnitude expected %0d actual %0d", $time, e.magnitude, a.magnitude);
				errors++;
			end
			if (a.new_peak !== e.new_peak) begin
				$display("%0t: new_peak expected %0b actual %0b", $time, e.new_peak, a.new_peak);
				errors++;
			end
		endfunction
	endclass

	logic                                 clk;
	logic                                 arst_n;
	logic                                 in_tvalid;
	logic                                 in_tready;
	logic [pcpd_pkg::IN_TDATA_W-1:0]      in_tdata;
	logic                                 out_tvalid;
	logic                                 out_tready = 1'b0;
	logic [pcpd_pkg::OUT_TDATA_W-1:0]     out_tdata;
	logic                                 cfg_wen;
	logic [pcpd_pkg::CFG_IDX_W-1:0]       cfg_idx;
	logic [pcpd_pkg::CFG_W-1:0]           cfg_wdata;

	corr_scoreboard sb = new();
	bit calm;
	int sent;
	int stall_left;
	int idle_cycles;

	preamble_correlator_peak_detect #(
		.PREAMBLE_SYMBOLS(NSYM),
		.SAMPLES_PER_SYMBOL(SPS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_tvalid(in_tvalid),
		.in_tready(in_tready),
		.in_tdata(in_tdata),
		.out_tvalid(out_tvalid),
		.out_tready(out_tready),
		.out_tdata(out_tdata),
		.cfg_wen(cfg_wen),
		.cfg_idx(cfg_idx),
		.cfg_wdata(cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// result side: check, then pick next ready
	always @(posedge clk) begin
		if (arst_n && out_tvalid && out_tready)
			sb.check_result(out_tdata);
		if (stall_left > 0) begin
			stall_left--;
			out_tready <= 1'b0;
		end else if (!calm && $urandom_range(0, 7) == 0) begin
			stall_left = $urandom_range(1, 16) - 1;
			out_tready <= 1'b0;
		end else begin
			out_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_tvalid && in_tready) || (out_tvalid && out_tready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	function automatic logic [SW-1:0] to_sample(int v);
		if (v > 32767)
			v = 32767;
		else if (v < -32768)
			v = -32768;
		return v[SW-1:0];
	endfunction

	function automatic logic [SW-1:0] rand_sample();
		logic [31:0] r;
		r = $urandom;
		return r[SW-1:0];
	endfunction

	function automatic int noise();
		return int'($urandom_range(0, 1000)) - 500;
	endfunction

	task automatic send_sample(input logic [SW-1:0] si, input logic [SW-1:0] sq);
		pcpd_pkg::pcpd_iq_t s;
		s.i = si;
		s.q = sq;
		if (!calm && $urandom_range(0, 4) == 0) begin
			in_tvalid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
		in_tvalid <= 1'b1;
		in_tdata <= s;
		do
			@(posedge clk);
		while (!in_tready);
		sb.note_sample(s);
		sent++;
	endtask

	task automatic send_preamble(input int amp_i, input int amp_q, input bit broken);
		bit b;
		for (int k = NSYM - 1; k >= 0; k--) begin
			b = sb.pat[k];
			if (broken && $urandom_range(0, 7) == 0)
				b = !b;
			for (int r = 0; r < SPS; r++)
				send_sample(to_sample((b ? amp_i : -amp_i) + noise()),
					to_sample((b ? amp_q : -amp_q) + noise()));
		end
	endtask

	// wait out the pipeline, then program both registers
	task automatic program_regs(input logic [pcpd_pkg::CFG_W-1:0] thr_v,
		input logic [pcpd_pkg::CFG_W-1:0] pat_v);
		in_tvalid <= 1'b0;
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		cfg_wen <= 1'b1;
		cfg_idx <= pcpd_pkg::REG_THRESHOLD;
		cfg_wdata <= thr_v;
		@(posedge clk);
		sb.set_reg(pcpd_pkg::REG_THRESHOLD, thr_v);
		cfg_idx <= pcpd_pkg::REG_PATTERN;
		cfg_wdata <= pat_v;
		@(posedge clk);
		sb.set_reg(pcpd_pkg::REG_PATTERN, pat_v);
		cfg_wen <= 1'b0;
	endtask

	initial begin
		logic [pcpd_pkg::CFG_W-1:0] thr_v, pat_v;
		int lo, hi, amp_i, amp_q, n;
		arst_n = 1'b0;
		in_tvalid = 1'b0;
		in_tdata = '0;
		cfg_wen = 1'b0;
		cfg_idx = pcpd_pkg::REG_THRESHOLD;
		cfg_wdata = '0;
		calm = 1'b0;
		sent = 0;
		stall_left = 0;
		idle_cycles = 0;
		sb.clear();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// extremes at reset settings, then with a mixed pattern
		send_sample(16'h7FFF, 16'h7FFF);
		send_sample(16'h8000, 16'h8000);
		send_sample(16'h8000, 16'h7FFF);
		send_sample(16'h0000, 16'h0000);
		program_regs(32'h0000_0000, 32'hA5A5_A5A5);
		send_sample(16'h7FFF, 16'h7FFF);
		send_sample(16'h7FFF, 16'h8000);
		send_sample(16'h0000, 16'h0000);
		send_sample(16'hFFFF, 16'hFFFF);
		send_sample(16'h0001, 16'hFFFF);
		send_sample(16'h5555, 16'hAAAA);
		send_sample(16'hAAAA, 16'h5555);
		repeat (8) send_sample(16'h8000, 16'h8000);
		repeat (4) send_sample(16'h7FFF, 16'h0000);

		for (int p = 0; p < 5; p++) begin
			case (p)
				0: begin thr_v = 32'hFFFF_FFFF; pat_v = 32'hFFFF_FFFF; end
				1: begin thr_v = 32'h0000_0000; pat_v = $urandom; end
				2: begin thr_v = $urandom_range(0, 400000); pat_v = $urandom; end
				3: begin thr_v = $urandom; pat_v = 32'h0000_0000; end
				default: begin thr_v = $urandom_range(0, 100000); pat_v = $urandom; end
			endcase
			program_regs(thr_v, pat_v);
			lo = (p + 1) * 5000;
			hi = (p + 1) * 6500;
			if (hi > 32767)
				hi = 32767;
			n = sent + PHASE_ITEMS;
			while (sent < n) begin
				calm = (p == 4) || ($urandom_range(0, 3) == 0);
				if ($urandom_range(0, 9) < 6) begin
					amp_i = $urandom_range(lo, hi);
					amp_q = $urandom_range(0, hi);
					if ($urandom_range(0, 1))
						send_preamble(amp_i, amp_q, $urandom_range(0, 3) == 0);
					else
						send_preamble(amp_q, amp_i, $urandom_range(0, 3) == 0);
					repeat ($urandom_range(0, 8))
						send_sample(to_sample(noise()), to_sample(noise()));
				end else begin
					repeat ($urandom_range(1, 30))
						send_sample(rand_sample(), rand_sample());
				end
			end
		end
		send_preamble(32767, 32767, 1'b0);

		in_tvalid <= 1'b0;
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (sb.errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
